FILE: design/sbg_pkg.sv
// ----------------------------------------------------------------------------
// sbg_pkg: shared types and constants for the sine burst generator
// Field widths, command/status structs and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package sbg_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int MAX_BURST       = 64;

  // Port field widths
  localparam int PHASE_WIDTH  = 32;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COUNT_WIDTH  = 7;
  localparam int DATA_WIDTH   = 32;
  localparam int PADDR_WIDTH  = 3;

  localparam int TABLE_N     = 1 << TABLE_ADDR_BITS;
  localparam int BURST_WIDTH = $clog2(MAX_BURST + 1);

  // Register map: index is paddr[2]
  localparam logic REG_PHASE_STEP = 1'b0;

  localparam logic [COUNT_WIDTH-1:0] MAX_BURST_C = COUNT_WIDTH'(MAX_BURST);
  localparam logic [TABLE_ADDR_BITS:0] TABLE_TOP = {1'b1, {TABLE_ADDR_BITS{1'b0}}};

  typedef struct packed {
    logic load;   // load start phase into accumulator
    logic issue;  // emit a sample from the accumulator and advance it
    logic last;   // issued sample closes the burst
  } sbg_cmd_t;

  typedef struct packed {
    logic advance;  // sample pipeline can take a new sample
  } sbg_status_t;

  // Quarter-wave table, built at elaboration with integer arithmetic only
  typedef logic [SAMPLE_BITS-2:0] qtab_entry_t;
  typedef qtab_entry_t qtab_t [0:TABLE_N];

  localparam logic [63:0] PIH_Q30 = 64'd1686629713;
  localparam logic [63:0] AMP     = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam int TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

  function automatic qtab_entry_t qtab_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    longint      sum;
    x    = (PIH_Q30 * 64'(k) + 64'(TABLE_N / 2)) >> TABLE_ADDR_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[n]);
      if ((n % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (64'(sum) * AMP + (64'd1 << 29)) >> 30;
    if (v > AMP) begin
      v = AMP;
    end
    return qtab_entry_t'(v);
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int k = 0; k <= TABLE_N; k++) begin
      t[k] = qtab_entry(k);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

endpackage

FILE: design/sbg_req_if.sv
// ----------------------------------------------------------------------------
// sbg_req_if: burst request channel
// Valid/ready handshake carrying one burst request.
// ----------------------------------------------------------------------------
interface sbg_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] start_phase;
  logic [6:0]  sample_count;

  modport source (output valid, req_type, start_phase, sample_count, input ready);
  modport sink   (input valid, req_type, start_phase, sample_count, output ready);
endinterface

FILE: design/sbg_smp_if.sv
// ----------------------------------------------------------------------------
// sbg_smp_if: sample channel
// Valid/ready handshake carrying one phase/sine sample.
// ----------------------------------------------------------------------------
interface sbg_smp_if;
  logic               valid;
  logic               ready;
  logic [31:0]        phase_word;
  logic signed [15:0] sample_value;
  logic               last_sample;

  modport source (output valid, phase_word, sample_value, last_sample, input ready);
  modport sink   (input valid, phase_word, sample_value, last_sample, output ready);
endinterface

FILE: design/sbg_regs.sv
// ----------------------------------------------------------------------------
// sbg_regs: configuration register block
// APB-style slave holding the phase step register.
// ----------------------------------------------------------------------------
module sbg_regs import sbg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0]  pwdata,
  output logic [DATA_WIDTH-1:0]  prdata,
  output logic                   pready,
  output logic [DATA_WIDTH-1:0]  phase_step
);

  logic reg_index;
  logic wr_en;

  assign reg_index = paddr[2];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
    end else if (wr_en && (reg_index == REG_PHASE_STEP)) begin
      phase_step <= pwdata;
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_PHASE_STEP: prdata = phase_step;
      default:        prdata = '0;
    endcase
  end

endmodule

FILE: design/sbg_qrom.sv
// ----------------------------------------------------------------------------
// sbg_qrom: quarter-wave sine ROM
// Registered read of the constant quarter-wave magnitude table.
// ----------------------------------------------------------------------------
module sbg_qrom import sbg_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [TABLE_ADDR_BITS:0] addr,
  output qtab_entry_t              data
);

  always_ff @(posedge clk) begin
    if (en) begin
      data <= QTAB[addr];
    end
  end

endmodule

FILE: design/sbg_datapath.sv
// ----------------------------------------------------------------------------
// sbg_datapath: phase accumulator and sample pipeline
// Accumulator, table lookup stage and output register with a global stall.
// ----------------------------------------------------------------------------
module sbg_datapath import sbg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  sbg_cmd_t                cmd,
  output sbg_status_t             stat,
  input  logic [PHASE_WIDTH-1:0]  start_phase,
  input  logic [DATA_WIDTH-1:0]   phase_step,
  input  logic                    smp_ready,
  output logic                    smp_valid,
  output logic [PHASE_WIDTH-1:0]  phase_word,
  output logic signed [SAMPLE_WIDTH-1:0] sample_value,
  output logic                    last_sample
);

  logic [PHASE_BITS-1:0]      phase_acc;
  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-1:0] idx;
  logic [TABLE_ADDR_BITS:0]   rom_addr;
  qtab_entry_t                rom_data;
  logic                       advance;

  // lookup stage
  logic                  a_valid;
  logic [PHASE_BITS-1:0] a_phase;
  logic                  a_neg;
  logic                  a_last;

  logic signed [SAMPLE_BITS-1:0] mag;
  logic signed [SAMPLE_BITS-1:0] sine_val;

  // stall issue and the pipeline while the output register holds an untaken sample
  assign advance      = !smp_valid || smp_ready;
  assign stat.advance = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (cmd.load) begin
      phase_acc <= PHASE_BITS'(start_phase);
    end else if (cmd.issue) begin
      phase_acc <= phase_acc + PHASE_BITS'(phase_step);
    end
  end

  // odd quadrants read the table mirrored
  assign quad     = phase_acc[PHASE_BITS-1 -: 2];
  assign idx      = phase_acc[PHASE_BITS-3 -: TABLE_ADDR_BITS];
  assign rom_addr = quad[0] ? (TABLE_TOP - {1'b0, idx}) : {1'b0, idx};

  sbg_qrom u_qrom (
    .clk  (clk),
    .en   (advance),
    .addr (rom_addr),
    .data (rom_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      smp_valid <= 1'b0;
    end else if (advance) begin
      a_valid   <= cmd.issue;
      smp_valid <= a_valid;
    end
  end

  assign mag      = signed'({1'b0, rom_data});
  assign sine_val = a_neg ? -mag : mag;

  always_ff @(posedge clk) begin
    if (advance) begin
      a_phase      <= phase_acc;
      a_neg        <= quad[1];
      a_last       <= cmd.last;
      phase_word   <= PHASE_WIDTH'(a_phase);
      sample_value <= SAMPLE_WIDTH'(sine_val);
      last_sample  <= a_last;
    end
  end

endmodule

FILE: design/sbg_ctrl.sv
// ----------------------------------------------------------------------------
// sbg_ctrl: burst controller
// Takes a request, optionally loads the start phase and issues the burst's samples.
// ----------------------------------------------------------------------------
module sbg_ctrl import sbg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  input  logic                   req_type,
  input  logic [COUNT_WIDTH-1:0] sample_count,
  output logic                   req_ready,
  output sbg_cmd_t               cmd,
  input  sbg_status_t            stat
);

  typedef enum logic {IDLE, RUN} state_t;

  state_t                 state;
  logic [BURST_WIDTH-1:0] remain;
  logic [BURST_WIDTH-1:0] count_sat;
  logic                   accept;

  assign req_ready = (state == IDLE);
  assign accept    = req_valid && req_ready;

  // saturate the burst length
  assign count_sat = (sample_count > MAX_BURST_C) ? BURST_WIDTH'(MAX_BURST)
                                                   : BURST_WIDTH'(sample_count);

  assign cmd.load  = accept && req_type;
  assign cmd.issue = (state == RUN) && stat.advance;
  assign cmd.last  = (remain == BURST_WIDTH'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      remain <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (accept) begin
            remain <= count_sat;
            if (count_sat != '0) begin
              state <= RUN;
            end
          end
        end
        RUN: begin
          if (cmd.issue) begin
            remain <= remain - BURST_WIDTH'(1);
            if (cmd.last) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: design/sine_burst_generator_core.sv
// ----------------------------------------------------------------------------
// sine_burst_generator_core: DDS sine burst generator
// Numerically controlled oscillator emitting bursts of phase/sine samples.
// ----------------------------------------------------------------------------
// Each request optionally loads a start phase, then produces sample_count
// samples (saturated to 64; a count of zero produces none) at one sample per
// cycle while the sample sink keeps ready high. The request channel is busy
// while the burst's samples are issued and accepts the next request in the
// cycle after the last sample is issued; a zero-count request leaves it ready.
// Each sample passes a registered lookup into the 1025-entry quarter-wave ROM
// and the sign stage before the output register. The phase advances by the
// phase_step register (byte address 0) after every sample and wraps modulo
// 2^32; write it only while idle.
module sine_burst_generator_core import sbg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  sbg_req_if.sink                req,
  sbg_smp_if.source              smp,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0]  pwdata,
  output logic [DATA_WIDTH-1:0]  prdata,
  output logic                   pready
);

  logic [DATA_WIDTH-1:0] phase_step;
  sbg_cmd_t              cmd;
  sbg_status_t           stat;

  sbg_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .phase_step (phase_step)
  );

  sbg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req.valid),
    .req_type     (req.req_type),
    .sample_count (req.sample_count),
    .req_ready    (req.ready),
    .cmd          (cmd),
    .stat         (stat)
  );

  sbg_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .start_phase  (req.start_phase),
    .phase_step   (phase_step),
    .smp_ready    (smp.ready),
    .smp_valid    (smp.valid),
    .phase_word   (smp.phase_word),
    .sample_value (smp.sample_value),
    .last_sample  (smp.last_sample)
  );

endmodule

FILE: design/sbg_checker.sv
// ----------------------------------------------------------------------------
// sbg_checker: port-level checks for the sine burst generator
// Bound to the top level; watches the request, sample and register ports.
// ----------------------------------------------------------------------------
module sbg_checker import sbg_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_ready,
  input logic [COUNT_WIDTH-1:0] sample_count,
  input logic                   smp_valid,
  input logic                   smp_ready,
  input logic [PHASE_WIDTH-1:0] phase_word,
  input logic [SAMPLE_WIDTH-1:0] sample_value,
  input logic                   last_sample,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic [PADDR_WIDTH-1:0] paddr,
  input logic [DATA_WIDTH-1:0]  pwdata,
  input logic [DATA_WIDTH-1:0]  prdata
);

  // come out of reset empty and ready for a request
  a_reset_state: assert property (@(posedge clk)
    rst |=> !smp_valid && req_ready)
    else $error("not idle after reset");

  // a request with samples to emit keeps the channel busy
  a_busy_after_burst: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (sample_count != '0) |=> !req_ready)
    else $error("request taken while burst pending");

  // a zero-count request completes at once
  a_zero_count_idle: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (sample_count == '0) |=> req_ready)
    else $error("zero-count request left block busy");

  // phase step reads back what was written
  a_step_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr[2] == REG_PHASE_STEP)
    |=> (paddr[2] != REG_PHASE_STEP) || (prdata == $past(pwdata)))
    else $error("phase step readback mismatch");

  a_smp_hold: assert property (@(posedge clk) disable iff (rst)
    smp_valid && !smp_ready |=> smp_valid && $stable(phase_word)
      && $stable(sample_value) && $stable(last_sample))
    else $error("stalled sample changed");

endmodule

bind sine_burst_generator_core sbg_checker u_sbg_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .sample_count (req.sample_count),
  .smp_valid    (smp.valid),
  .smp_ready    (smp.ready),
  .phase_word   (smp.phase_word),
  .sample_value (smp.sample_value),
  .last_sample  (smp.last_sample),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata)
);
